/* hdl/chi_pkg.sv */
// Shared types and constants for the compass heading interpolator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package chi_pkg;

    localparam int TIME_W        = 10;
    localparam int HEADING_W     = 16;
    localparam int ANGLE_W       = 16;
    localparam int MS_PER_SEC    = 1000;
    localparam int MS_MAX        = 999;
    localparam int FULL_TURN_DEF = 65536;

    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WRAP,
        ST_APPLY
    } top_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

endpackage

/* hdl/chi_muldiv.sv */
// Bit-serial unit: magnitude times elapsed time, then divided by the span.
// Shift-add multiply followed by restoring division; depends on chi_pkg.
`timescale 1ns / 1ps

module chi_muldiv #(
    parameter int FULL_TURN = chi_pkg::FULL_TURN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(FULL_TURN)-1:0]  mag,
    input  logic [chi_pkg::TIME_W-1:0]    el,
    input  logic [chi_pkg::TIME_W-1:0]    span,
    output logic                          busy,
    output logic [$clog2(FULL_TURN)-1:0]  quotient
);

    localparam int ANG_W = $clog2(FULL_TURN);
    localparam int EL_W  = chi_pkg::TIME_W;
    localparam int P_W   = ANG_W + EL_W;
    localparam int CNT_W = $clog2(P_W + 1);

    chi_pkg::md_state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [P_W-1:0]     prod_reg, prod_next;
    logic [P_W-1:0]     mcand_reg, mcand_next;
    logic [EL_W-1:0]    mplier_reg, mplier_next;
    logic [EL_W-1:0]    span_reg, span_next;
    logic [EL_W-1:0]    rem_reg, rem_next;
    logic [EL_W:0]      rem_sh;
    logic               qbit;

    always_comb
    begin
        rem_sh = {rem_reg, prod_reg[P_W-1]};
        qbit   = (rem_sh >= {1'b0, span_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chi_pkg::MD_IDLE:
            begin
                if (start)
                    state_next = chi_pkg::MD_MUL;
            end
            chi_pkg::MD_MUL:
            begin
                if (cnt_reg == '0)
                    state_next = chi_pkg::MD_DIV;
            end
            chi_pkg::MD_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = chi_pkg::MD_IDLE;
            end
            default:
                state_next = chi_pkg::MD_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        span_next   = span_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            chi_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    cnt_next    = CNT_W'(EL_W - 1);
                    prod_next   = '0;
                    mcand_next  = P_W'(mag);
                    mplier_next = el;
                    span_next   = span;
                end
            end
            chi_pkg::MD_MUL:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next  = {mcand_reg[P_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[EL_W-1:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next = CNT_W'(P_W - 1);
                    rem_next = '0;
                end
            end
            chi_pkg::MD_DIV:
            begin
                rem_next  = qbit ? EL_W'(rem_sh - {1'b0, span_reg}) : rem_sh[EL_W-1:0];
                prod_next = {prod_reg[P_W-2:0], qbit};
                cnt_next  = cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chi_pkg::MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
    end

    assign busy     = (state_reg != chi_pkg::MD_IDLE);
    assign quotient = prod_reg[ANG_W-1:0];

endmodule

/* hdl/chi_hdgmod.sv */
// Bit-serial reduction of the incoming heading modulo one full turn.
// One heading bit per cycle, MSB first; depends on chi_pkg.
`timescale 1ns / 1ps

module chi_hdgmod #(
    parameter int FULL_TURN = chi_pkg::FULL_TURN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chi_pkg::HEADING_W-1:0] heading,
    output logic                          busy,
    output logic [$clog2(FULL_TURN)-1:0]  residue
);

    localparam int ANG_W = $clog2(FULL_TURN);
    localparam int RED_W = ANG_W + 1;
    localparam int HDG_W = chi_pkg::HEADING_W;
    localparam int CNT_W = $clog2(HDG_W + 1);
    localparam logic [RED_W-1:0] TURN = RED_W'(FULL_TURN);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [HDG_W-1:0] hdg_reg, hdg_next;
    logic [ANG_W-1:0] r_reg, r_next;
    logic [RED_W-1:0] r_sh;

    always_comb
    begin
        r_sh      = {r_reg, hdg_reg[HDG_W-1]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        hdg_next  = hdg_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            r_next   = (r_sh >= TURN) ? ANG_W'(r_sh - TURN) : r_sh[ANG_W-1:0];
            hdg_next = {hdg_reg[HDG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(HDG_W - 1);
            hdg_next  = heading;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdg_reg <= hdg_next;
        r_reg   <= r_next;
    end

    assign busy    = busy_reg;
    assign residue = r_reg;

endmodule

/* hdl/compass_heading_interpolator_top.sv */
// Compass heading interpolator: control, heading state and output register.
// Instantiates chi_muldiv and chi_hdgmod; depends on chi_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries func, time_ms and
//   heading_angle. A query transaction (func = 0) yields one angle on the
//   output channel (out_valid / out_stall); an update (func = 1) yields none
//   and replaces the stored base angle, interval, stamp and step.
//   Each transaction runs from acceptance through the bit-serial multiply
//   and restoring divide in chi_muldiv, alongside the heading reduction in
//   chi_hdgmod, then through the wrap, apply and idle steps before the next
//   acceptance. A query result is loaded into the output register in its
//   apply step. in_stall is high while a transaction is in flight. If the
//   output is stalled, a finished query holds in its last step until the
//   output register frees; a pending result does not block the next input.
//   Reset clears the state to a zero base, zero step, zero stamp and a zero
//   interval, which acts as one millisecond.
`timescale 1ns / 1ps

module compass_heading_interpolator_top #(
    parameter int FULL_TURN = chi_pkg::FULL_TURN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [chi_pkg::TIME_W-1:0]    time_ms,
    input  logic [chi_pkg::HEADING_W-1:0] heading_angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [chi_pkg::ANGLE_W-1:0]   angle
);

    localparam int ANG_W = $clog2(FULL_TURN);
    localparam int DLT_W = ANG_W + 1;
    localparam int EXT_W = ANG_W + 2;
    localparam int TW    = chi_pkg::TIME_W;
    localparam int AW    = chi_pkg::ANGLE_W;
    localparam logic signed [EXT_W-1:0] TURN_S = EXT_W'(FULL_TURN);
    localparam logic signed [EXT_W-1:0] HALF_S = EXT_W'(FULL_TURN / 2);
    localparam logic [TW-1:0] MS_MAX_C = TW'(chi_pkg::MS_MAX);
    localparam logic [TW:0]   MS_SEC_C = (TW + 1)'(chi_pkg::MS_PER_SEC);

    chi_pkg::top_state_t state_reg, state_next;

    logic                    func_reg, func_next;
    logic [TW-1:0]           now_reg, now_next;
    logic [TW-1:0]           elapsed_reg, elapsed_next;
    logic [ANG_W-1:0]        curr_reg, curr_next;
    logic signed [DLT_W-1:0] step_delta_reg, step_delta_next;
    logic [ANG_W-1:0]        base_reg, base_next;
    logic [TW-1:0]           interval_reg, interval_next;
    logic [TW-1:0]           stamp_reg, stamp_next;
    logic                    out_valid_reg, out_valid_next;
    logic [AW-1:0]           angle_reg, angle_next;

    logic accept, out_free;
    logic md_start, md_busy, rd_busy;
    logic out_load, state_upd;

    logic [TW-1:0]    now_c, span_c, el_c, elapsed_c;
    logic [TW:0]      elapsed_w;
    logic [ANG_W-1:0] mag_c, quotient, residue;
    logic signed [EXT_W-1:0] q_s, a_c, d_c, d1_c, d2_c;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        now_c     = (time_ms > MS_MAX_C) ? MS_MAX_C : time_ms;
        elapsed_w = (now_c > stamp_reg) ? {1'b0, now_c} - {1'b0, stamp_reg}
                                        : {1'b0, now_c} + MS_SEC_C - {1'b0, stamp_reg};
        elapsed_c = elapsed_w[TW-1:0];
        span_c    = (interval_reg == '0) ? TW'(1) : interval_reg;
        el_c      = (elapsed_c > span_c) ? span_c : elapsed_c;
        mag_c     = step_delta_reg[DLT_W-1] ? ANG_W'(-step_delta_reg)
                                            : ANG_W'(step_delta_reg);
    end

    always_comb
    begin
        q_s = $signed({2'b00, quotient});
        if (step_delta_reg[DLT_W-1])
            q_s = -q_s;
        a_c = q_s + $signed({2'b00, base_reg});
        if (a_c < 0)
            a_c = a_c + TURN_S;
        else if (a_c >= TURN_S)
            a_c = a_c - TURN_S;
    end

    always_comb
    begin
        d_c  = $signed({2'b00, residue}) - $signed({2'b00, curr_reg});
        d1_c = (d_c < -HALF_S) ? d_c + TURN_S : d_c;
        d2_c = (d1_c > HALF_S) ? d1_c - TURN_S : d1_c;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chi_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = chi_pkg::ST_CALC;
            end
            chi_pkg::ST_CALC:
            begin
                if (!md_busy && !rd_busy)
                    state_next = chi_pkg::ST_WRAP;
            end
            chi_pkg::ST_WRAP:
                state_next = chi_pkg::ST_APPLY;
            chi_pkg::ST_APPLY:
            begin
                if (func_reg == chi_pkg::FUNC_UPDATE || out_free)
                    state_next = chi_pkg::ST_IDLE;
            end
            default:
                state_next = chi_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        md_start  = 1'b0;
        out_load  = 1'b0;
        state_upd = 1'b0;
        unique case (state_reg)
            chi_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                md_start = in_valid;
            end
            chi_pkg::ST_CALC:
                in_stall = 1'b1;
            chi_pkg::ST_WRAP:
                in_stall = 1'b1;
            chi_pkg::ST_APPLY:
            begin
                out_load  = (func_reg == chi_pkg::FUNC_QUERY) && out_free;
                state_upd = (func_reg == chi_pkg::FUNC_UPDATE);
            end
            default:
                in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        curr_next       = curr_reg;
        step_delta_next = step_delta_reg;
        base_next       = base_reg;
        interval_next   = interval_reg;
        stamp_next      = stamp_reg;
        angle_next      = angle_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (accept)
        begin
            func_next    = func;
            now_next     = now_c;
            elapsed_next = elapsed_c;
        end
        if (state_reg == chi_pkg::ST_WRAP)
            curr_next = a_c[ANG_W-1:0];
        if (out_load)
        begin
            out_valid_next = 1'b1;
            angle_next     = AW'(curr_reg);
        end
        if (state_upd)
        begin
            step_delta_next = d2_c[DLT_W-1:0];
            base_next       = curr_reg;
            interval_next   = elapsed_reg;
            stamp_next      = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chi_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            step_delta_reg <= '0;
            base_reg       <= '0;
            interval_reg   <= '0;
            stamp_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            step_delta_reg <= step_delta_next;
            base_reg       <= base_next;
            interval_reg   <= interval_next;
            stamp_reg      <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        curr_reg    <= curr_next;
        angle_reg   <= angle_next;
    end

    chi_muldiv #(
        .FULL_TURN (FULL_TURN)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .mag      (mag_c),
        .el       (el_c),
        .span     (span_c),
        .busy     (md_busy),
        .quotient (quotient)
    );

    chi_hdgmod #(
        .FULL_TURN (FULL_TURN)
    ) u_hdgmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .heading (heading_angle),
        .busy    (rd_busy),
        .residue (residue)
    );

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

/* hdl/chi_checker.sv */
// Port-level checks for the compass heading interpolator top level.
// Bound to compass_heading_interpolator_top; depends on chi_pkg.
`timescale 1ns / 1ps

module chi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [chi_pkg::ANGLE_W-1:0] angle
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("stalled output transaction changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("input taken again too soon after a transaction");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no transaction in flight");

endmodule

bind compass_heading_interpolator_top chi_checker u_chi_checker (.*);

/* tb/tb_compass_heading_interpolator_top.sv */
// Self-checking testbench for compass_heading_interpolator_top: a table of directed
// transactions, then random queries and updates, checked against an interpolating predictor.
// Depends on chi_pkg and the top level only; random idling on both channels.
`timescale 1ns / 1ps

module tb_compass_heading_interpolator_top;

    localparam int FULL        = chi_pkg::FULL_TURN_DEF;
    localparam int HALF        = FULL / 2;
    localparam int TW          = chi_pkg::TIME_W;
    localparam int HW          = chi_pkg::HEADING_W;
    localparam int AW          = chi_pkg::ANGLE_W;
    localparam int PLAN_ROWS   = 22;
    localparam int RAND_ITEMS  = 1550;
    localparam int TOTAL       = PLAN_ROWS + RAND_ITEMS;
    localparam int CALM_TAIL   = 150;
    localparam int CYCLE_LIMIT = TOTAL * 200 + 2000;

    typedef struct {
        logic          fn;
        logic [TW-1:0] t;
        logic [HW-1:0] h;
        bit            known;
        logic [AW-1:0] want;
    } row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          func = chi_pkg::FUNC_QUERY;
    logic [TW-1:0] time_ms = '0;
    logic [HW-1:0] heading_angle = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [AW-1:0] angle;

    logic signed [17:0] hdg_step = '0;
    logic [16:0]        hdg_base = '0;
    logic [TW-1:0]      hdg_span = '0;
    logic [TW-1:0]      hdg_stamp = '0;

    logic [AW-1:0] pending_angles[$];
    logic [AW-1:0] want_angle;
    bit            calm = 1'b0;
    int            stall_left = 0;
    int            errors = 0;
    int            cycles = 0;

    compass_heading_interpolator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .time_ms       (time_ms),
        .heading_angle (heading_angle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .angle         (angle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ms_elapsed(int unsigned now, int unsigned then);
        if (now > then)
            return now - then;
        return now + chi_pkg::MS_PER_SEC - then;
    endfunction

    function automatic int unsigned clamp_ms(logic [TW-1:0] t);
        return (t > chi_pkg::MS_MAX) ? chi_pkg::MS_MAX : t;
    endfunction

    function automatic longint interp_heading(int unsigned now);
        longint span;
        longint el;
        longint stp;
        longint bas;
        longint a;
        span = (hdg_span == 0) ? 1 : hdg_span;
        el = ms_elapsed(now, hdg_stamp);
        stp = hdg_step;
        bas = hdg_base;
        if (el > span)
            el = span;
        a = stp * el / span + bas;
        if (a < 0)
            a += FULL;
        else if (a >= FULL)
            a -= FULL;
        return a;
    endfunction

    // Advance the heading state on an update; return 1 when the transaction yields an angle.
    function automatic bit track_transaction(logic fn, logic [TW-1:0] t,
                                             logic [HW-1:0] h,
                                             output logic [AW-1:0] ang);
        int unsigned now;
        longint      curr;
        longint      d;
        now = clamp_ms(t);
        curr = interp_heading(now);
        ang = curr[AW-1:0];
        if (fn == chi_pkg::FUNC_QUERY)
            return 1'b1;
        d = h;
        d = d - curr;
        if (d < -HALF)
            d += FULL;
        if (d > HALF)
            d -= FULL;
        hdg_span = TW'(ms_elapsed(now, hdg_stamp));
        hdg_stamp = TW'(now);
        hdg_base = 17'(curr);
        hdg_step = 18'(d);
        return 1'b0;
    endfunction

    initial
    begin
        row_t          plan[PLAN_ROWS];
        logic          fn;
        logic [TW-1:0] t;
        logic [HW-1:0] h;
        logic [AW-1:0] ang;
        int            pick;
        int unsigned   now_ms;
        plan = '{
            '{chi_pkg::FUNC_QUERY,  10'd0,    16'h0000, 1'b1, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd1023, 16'hFFFF, 1'b1, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd100,  16'h8000, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd150,  16'h0000, 1'b1, 16'd16384},
            '{chi_pkg::FUNC_QUERY,  10'd100,  16'h0000, 1'b1, 16'd32768},
            '{chi_pkg::FUNC_QUERY,  10'd200,  16'h0000, 1'b1, 16'd32768},
            '{chi_pkg::FUNC_UPDATE, 10'd300,  16'h0000, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd400,  16'h0000, 1'b1, 16'd16384},
            '{chi_pkg::FUNC_QUERY,  10'd500,  16'h0000, 1'b1, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd301,  16'hFFFF, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd301,  16'h0000, 1'b1, 16'd65535},
            '{chi_pkg::FUNC_UPDATE, 10'd301,  16'h0001, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd800,  16'h0000, 1'b1, 16'd65535},
            '{chi_pkg::FUNC_QUERY,  10'd300,  16'h0000, 1'b1, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd0,    16'h5555, 1'b0, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd0,    16'hAAAA, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd1000, 16'h0000, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd341,  16'h0000, 1'b0, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd682,  16'h1234, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd512,  16'h0000, 1'b0, 16'd0},
            '{chi_pkg::FUNC_UPDATE, 10'd1023, 16'hFFFF, 1'b0, 16'd0},
            '{chi_pkg::FUNC_QUERY,  10'd999,  16'h0000, 1'b0, 16'd0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < TOTAL; i++)
        begin
            calm = (i % 300 < 50) || (i >= TOTAL - CALM_TAIL);
            if (i < PLAN_ROWS)
            begin
                fn = plan[i].fn;
                t = plan[i].t;
                h = plan[i].h;
            end
            else
            begin
                fn = ($urandom_range(0, 1) == 0) ? chi_pkg::FUNC_QUERY : chi_pkg::FUNC_UPDATE;
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    t = TW'($urandom_range(0, 1023));
                else if (pick == 6)
                    t = hdg_stamp;
                else if (pick == 7)
                    t = TW'((hdg_stamp + $urandom_range(1, 20)) % chi_pkg::MS_PER_SEC);
                else if (pick == 8)
                    t = TW'((hdg_stamp + chi_pkg::MS_PER_SEC - $urandom_range(1, 20))
                            % chi_pkg::MS_PER_SEC);
                else
                    t = TW'($urandom_range(1000, 1023));
                now_ms = clamp_ms(t);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    h = HW'($urandom);
                else if (pick < 9)
                    h = HW'(interp_heading(now_ms) + HALF);
                else
                    h = HW'(interp_heading(now_ms) + $urandom_range(0, 64) - 32);
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            in_valid <= 1'b1;
            func <= fn;
            time_ms <= t;
            heading_angle <= h;
            do
                @(posedge clk);
            while (in_stall !== 1'b0);
            if (track_transaction(fn, t, h, ang))
                pending_angles.push_back((i < PLAN_ROWS && plan[i].known) ? plan[i].want : ang);
        end
        in_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("angle: expected none, actual %0d", angle);
                errors++;
            end
            else
            begin
                want_angle = pending_angles.pop_front();
                if (angle !== want_angle)
                begin
                    $error("angle: expected %0d, actual %0d", want_angle, angle);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
